// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define PPC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/ppc_pkg.sv =====
`default_nettype none
package ppc_pkg;

  // widest table index (page count up to 64k)
  localparam int unsigned IdxMaxW = 16;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_FAULT = 2'd2;

  localparam logic [2:0] PERM_R = 3'h1;
  localparam logic [2:0] PERM_W = 3'h2;
  localparam logic [2:0] PERM_X = 3'h4;
  localparam logic [2:0] PERM_ALL = 3'h7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_PAGE  = 3'd1;
  localparam logic [2:0] ST_FAULT     = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_VIOLATION = 3'd4;
  localparam logic [2:0] ST_NO_FRAME  = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] page_number;
    logic [31:0] vaddr;
    logic [2:0]  permission_bits;
    logic [2:0]  acc_kind;
  } ppc_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] frame_idx;
  } ppc_out_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] perms;
  } ppc_entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [IdxMaxW-1:0] rd_addr;
    logic               wr_en;
    logic [IdxMaxW-1:0] wr_addr;
    ppc_entry_t         wr_data;
  } ppc_tbl_req_t;

endpackage
`default_nettype wire

// ===== rtl/ppc_table.sv =====
`default_nettype none
`include "assert_macros.svh"
module ppc_table
  import ppc_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire ppc_tbl_req_t req_i,
  output ppc_entry_t        rd_data_o,
  output logic              ready_o
);

  localparam int unsigned AW = $clog2(PAGE_COUNT);

  ppc_entry_t     mem [PAGE_COUNT];
  ppc_entry_t     rd_data_q;
  logic           clearing_q, clearing_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic           clr_last;

  // sweep after reset: every page invalid with full access
  assign clr_last = (32'(clr_q) == PAGE_COUNT - 1);

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_last) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_q] <= '{valid: 1'b0, perms: PERM_ALL};
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clearing_q;

  `PPC_ASSERT(a_no_wr_while_clear, clearing_q |-> !req_i.wr_en, "write during clear sweep")
  `PPC_ASSERT(a_no_rd_wr_overlap, !(req_i.rd_en && req_i.wr_en), "read and write overlap")
  `PPC_ASSERT(a_clear_ends_at_last, $fell(clearing_q) |-> $past(clr_last), "sweep ended early")

endmodule
`default_nettype wire

// ===== rtl/ppc_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module ppc_ctrl
  import ppc_pkg::*;
#(
  parameter int unsigned PAGE_COUNT  = 1024,
  parameter int unsigned FRAME_COUNT = 1024,
  parameter int unsigned PAGE_BYTES  = 4096
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire ppc_in_t    in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output ppc_out_t        out_o,
  input  wire logic       tbl_ready_i,
  input  wire ppc_entry_t tbl_rd_i,
  output ppc_tbl_req_t    tbl_req_o
);

  // page size is a power of two, so the page is a shift of the address
  localparam int unsigned PageShift = $clog2(PAGE_BYTES);
  localparam int unsigned CW        = $clog2(FRAME_COUNT + 1);

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_e;

  state_e             state_q, state_d;
  logic [1:0]         cmd_q;
  logic [2:0]         perms_q, kind_q;
  logic               in_range_q;
  logic [IdxMaxW-1:0] idx_q;
  logic [CW-1:0]      next_frame_q, next_frame_d;
  logic               out_valid_q, out_valid_d;
  ppc_out_t           out_q, out_d;

  logic [31:0]        page_sel;
  logic               in_range;
  logic               accept;
  logic               done;
  logic               kind_ok;
  logic               frames_left;
  logic [31:0]        frame_ext;
  logic               wr_en;
  ppc_entry_t         wr_data;

  assign in_ready_o = (state_q == S_IDLE) && tbl_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign page_sel = (in_i.command == CMD_CHECK) ? (in_i.vaddr >> PageShift)
                                                : 32'(in_i.page_number);
  assign in_range = page_sel < 32'(PAGE_COUNT);

  // update may finish once the output word is free
  assign done        = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);
  assign kind_ok     = (kind_q == PERM_R) || (kind_q == PERM_W) || (kind_q == PERM_X);
  assign frames_left = next_frame_q < CW'(FRAME_COUNT);
  assign frame_ext   = 32'(next_frame_q);

  always_comb begin
    state_d      = state_q;
    next_frame_d = next_frame_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    wr_en        = 1'b0;
    wr_data      = '{valid: 1'b1, perms: perms_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (done) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_d       = '{status: ST_OK, frame_idx: '0};
          case (cmd_q)
            CMD_SET: begin
              if (!in_range_q) begin
                out_d.status = ST_BAD_PAGE;
              end else begin
                wr_en = 1'b1;
              end
            end
            CMD_CHECK: begin
              if (!in_range_q) begin
                out_d.status = ST_BAD_PAGE;
              end else if (!tbl_rd_i.valid) begin
                out_d.status = ST_FAULT;
              end else if (!kind_ok) begin
                out_d.status = ST_BAD_TYPE;
              end else if ((tbl_rd_i.perms & kind_q) != kind_q) begin
                out_d.status = ST_VIOLATION;
              end
            end
            CMD_FAULT: begin
              if (!in_range_q) begin
                out_d.status = ST_BAD_PAGE;
              end else if (!frames_left) begin
                out_d.status = ST_NO_FRAME;
              end else begin
                // keep permissions, only mark the page present
                wr_en           = 1'b1;
                wr_data         = '{valid: 1'b1, perms: tbl_rd_i.perms};
                out_d.frame_idx = frame_ext[9:0];
                next_frame_d    = next_frame_q + 1'b1;
              end
            end
            default: begin
              out_d.status = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      next_frame_q <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      cmd_q        <= '0;
      perms_q      <= '0;
      kind_q       <= '0;
      in_range_q   <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      next_frame_q <= next_frame_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      if (accept) begin
        cmd_q      <= in_i.command;
        perms_q    <= in_i.permission_bits;
        kind_q     <= in_i.acc_kind;
        in_range_q <= in_range;
        idx_q      <= page_sel[IdxMaxW-1:0];
      end
    end
  end

  assign tbl_req_o = '{rd_en:   accept,
                       rd_addr: page_sel[IdxMaxW-1:0],
                       wr_en:   wr_en,
                       wr_addr: idx_q,
                       wr_data: wr_data};

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `PPC_ASSERT(a_accept_to_update, accept |=> (state_q == S_UPDATE), "accept did not start update")
  `PPC_ASSERT(a_frame_bound, next_frame_q <= CW'(FRAME_COUNT), "frame counter overran")
  `PPC_ASSERT(a_word_from_update, $rose(out_valid_q) |-> $past(done), "word without update")
  `PPC_ASSERT(a_write_in_update, wr_en |-> (done && in_range_q), "table write outside update")

endmodule
`default_nettype wire

// ===== rtl/page_permission_checker_top.sv =====
// channel | direction | handshake                 | word
// in      | input     | in_valid_i / in_ready_o   | in_i   (ppc_in_t)
// out     | output    | out_valid_o / out_ready_i | out_o  (ppc_out_t)
//
// one command at a time: the page entry is read from the table at accept into
// its read register, then checked and written back in S_UPDATE once the output
// word is free. a new command can be taken in the cycle after the write-back;
// none is taken while one is in update.
// after reset the table sweeps all pages to clear them; no word is taken until
// it ends.
// a word waiting on out_o stalls the update; it holds until the word is taken.
`default_nettype none
module page_permission_checker_top
  import ppc_pkg::*;
#(
  parameter int unsigned PAGE_COUNT  = 1024,
  parameter int unsigned FRAME_COUNT = 1024,
  parameter int unsigned PAGE_BYTES  = 4096
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire ppc_in_t in_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output ppc_out_t     out_o
);

  ppc_tbl_req_t tbl_req;
  ppc_entry_t   tbl_rd;
  logic         tbl_ready;

  ppc_table #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tbl_req),
    .rd_data_o(tbl_rd),
    .ready_o  (tbl_ready)
  );

  ppc_ctrl #(
    .PAGE_COUNT (PAGE_COUNT),
    .FRAME_COUNT(FRAME_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .tbl_ready_i(tbl_ready),
    .tbl_rd_i   (tbl_rd),
    .tbl_req_o  (tbl_req)
  );

endmodule
`default_nettype wire
